// ----- rtl/core/mcwd_pkg.sv -----
// Shared types and constants for the multi-channel watchdog unit.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package mcwd_pkg;

  localparam int Channels = 8;
  localparam int ChW      = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int CntW     = $clog2(Channels + 1);
  localparam int PortChW  = 3;
  localparam int OpW      = 3;
  localparam int ValW     = 32;
  localparam int StepW    = 16;

  localparam logic [StepW-1:0] DefaultTickMs  = StepW'(100);
  localparam logic [ValW-1:0]  DefaultTimeout = ValW'(10 * 100);

  typedef enum logic [OpW-1:0] {
    OP_ALLOC   = 3'd0,
    OP_START   = 3'd1,
    OP_FEED    = 3'd2,
    OP_STOP    = 3'd3,
    OP_RELEASE = 3'd4,
    OP_TICK    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  typedef enum logic {
    KIND_REPLY  = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_TICK_STEP   = 1'b0,
    CFG_MIN_TIMEOUT = 1'b1
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic           load;      // capture an input transfer
    logic           exec;      // apply the latched command and load its reply
    logic           scan;      // update one channel for a tick
    logic [ChW-1:0] scan_idx;
    logic           emit;      // load the next expiry result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic armed_any;
    logic expire_any;
    logic slot_free;
  } stat_t;

endpackage

// ----- rtl/core/multi_channel_watchdog_unit.sv -----
// Top level of the multi-channel watchdog unit: controller plus datapath.
// Depends on mcwd_pkg, mcwd_ctrl and mcwd_dp.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   op_i selects allocate, start, feed, stop, release or tick; channel_i and
//   timeout_value_i are its operands. Output channel (out_valid_o /
//   out_stall_i) carries replies and expiry results; last_o marks the final
//   result of a command. Ops 0-4 give one reply, a tick gives one expiry
//   result per expired channel (lowest channel first) or none.
//   Configuration: write tick_step (index 0) or min_timeout (index 1) with
//   cfg_we_i while the unit is idle.
// Sequence
//   A command stalls the input from its transfer until its execute step,
//   which loads the reply into the output register once the slot is free.
//   A tick walks the channels one per cycle through the single compare/add
//   unit: the transfer, a scan of every channel, one expiry result per
//   expired channel (each waits for a free output slot), then a close. A
//   tick with no armed channel, and an unused op code, ends at its transfer.
//   The output register lets the next input transfer in while a result waits.
// Reset
//   All channels free and disarmed, counts zero, tick_step 100, min_timeout
//   1000. If the receiver stalls, the pending result holds and the unit
//   waits before loading the next one.
module multi_channel_watchdog_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [mcwd_pkg::ValW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mcwd_pkg::OpW-1:0]      op_i,
  input  logic [mcwd_pkg::PortChW-1:0]  channel_i,
  input  logic [mcwd_pkg::ValW-1:0]     timeout_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [1:0]                    status_o,
  output logic [mcwd_pkg::PortChW-1:0]  result_channel_o,
  output logic                          last_o
);
  import mcwd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: owns the handshake on the input side and the scan counter
  mcwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Channel state, configuration and the output register
  mcwd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .channel_i        (channel_i),
    .timeout_value_i  (timeout_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .status_o         (status_o),
    .result_channel_o (result_channel_o),
    .last_o           (last_o)
  );

  // Expiry results always carry an ok status
  a_expiry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_EXPIRY |-> status_o == ST_OK)
    else $error("expiry result with non-ok status");

  // A command reply is always the final result of its command
  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REPLY |-> last_o)
    else $error("command reply without last");

  // An allocate transfer blocks the input while its reply is pending
  a_cmd_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i == OP_ALLOC |=> in_stall_o)
    else $error("input accepted while a command is in flight");

endmodule

// ----- rtl/core/mcwd_ctrl.sv -----
// Sequencer for the watchdog unit: accepts transfers, runs the tick scan
// and the expiry emission. Depends on mcwd_pkg.
`timescale 1ns / 1ps

module mcwd_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [mcwd_pkg::OpW-1:0]  op_i,
  input  mcwd_pkg::stat_t           stat_i,
  output mcwd_pkg::cmd_t            cmd_o,
  output logic                      in_stall_o
);
  import mcwd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  logic [ChW-1:0] idx_q, idx_d;
  logic           scan_end;

  assign scan_end = (idx_q == ChW'(Channels - 1));

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmd_o        = '0;
    cmd_o.scan_idx = idx_q;
    in_stall_o   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (op_e'(op_i))
            OP_ALLOC, OP_START, OP_FEED, OP_STOP, OP_RELEASE: state_d = S_CMD;
            OP_TICK: begin
              // nothing armed: the tick is a no-op
              if (stat_i.armed_any) begin
                state_d = S_SCAN;
                idx_d   = '0;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CMD: begin
        if (stat_i.slot_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        idx_d      = idx_q + 1'b1;
        if (scan_end) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat_i.expire_any) begin
          state_d = S_IDLE;
        end else if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ----- rtl/core/mcwd_dp.sv -----
// Datapath for the watchdog unit: channel state, configuration registers,
// tick update and the output register. Depends on mcwd_pkg.
`timescale 1ns / 1ps

module mcwd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcwd_pkg::cmd_t                cmd_i,
  output mcwd_pkg::stat_t               stat_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [mcwd_pkg::ValW-1:0]     cfg_data_i,
  input  logic [mcwd_pkg::OpW-1:0]      op_i,
  input  logic [mcwd_pkg::PortChW-1:0]  channel_i,
  input  logic [mcwd_pkg::ValW-1:0]     timeout_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [1:0]                    status_o,
  output logic [mcwd_pkg::PortChW-1:0]  result_channel_o,
  output logic                          last_o
);
  import mcwd_pkg::*;

  logic [StepW-1:0]  tick_step_q;
  logic [ValW-1:0]   min_timeout_q;

  logic [Channels-1:0] in_use_q, armed_q, expire_q;
  logic [ValW-1:0]     elapsed_q [Channels];
  logic [ValW-1:0]     limit_q   [Channels];
  logic [CntW-1:0]     armed_total_q;

  logic [OpW-1:0]     op_q;
  logic [PortChW-1:0] chan_q;
  logic [ValW-1:0]    req_q;

  logic               out_valid_q, kind_q, last_q;
  logic [1:0]         status_q;
  logic [PortChW-1:0] res_chan_q;

  logic               alloc_hit, chan_ok, scan_exp, emit_last;
  logic [ChW-1:0]     alloc_idx, cidx, sidx, emit_idx;
  logic [ValW-1:0]    new_limit, sat_sum;
  logic [ValW:0]      sum;
  logic [Channels-1:0] expire_rest;
  logic               load_out;

  // Lowest free channel for allocate
  always_comb begin
    alloc_hit = 1'b0;
    alloc_idx = '0;
    for (int i = Channels - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        alloc_hit = 1'b1;
        alloc_idx = ChW'(i);
      end
    end
  end

  // Lowest pending expiry
  always_comb begin
    emit_idx = '0;
    for (int i = Channels - 1; i >= 0; i--) begin
      if (expire_q[i]) begin
        emit_idx = ChW'(i);
      end
    end
    expire_rest           = expire_q;
    expire_rest[emit_idx] = 1'b0;
    emit_last             = (expire_rest == '0);
  end

  assign cidx      = ChW'(chan_q);
  assign chan_ok   = (32'(chan_q) < 32'(Channels)) && in_use_q[cidx];
  assign new_limit = (req_q < min_timeout_q) ? min_timeout_q : req_q;

  assign sidx     = cmd_i.scan_idx;
  assign scan_exp = elapsed_q[sidx] > limit_q[sidx];
  assign sum      = {1'b0, elapsed_q[sidx]} + (ValW + 1)'(tick_step_q);
  assign sat_sum  = sum[ValW] ? '1 : sum[ValW-1:0];

  assign load_out = cmd_i.exec | cmd_i.emit;

  assign stat_o.armed_any  = (armed_total_q != '0);
  assign stat_o.expire_any = (expire_q != '0);
  assign stat_o.slot_free  = !out_valid_q || !out_stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q   <= DefaultTickMs;
      min_timeout_q <= DefaultTimeout;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TICK_STEP:   tick_step_q   <= cfg_data_i[StepW-1:0];
        CFG_MIN_TIMEOUT: min_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched input item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      chan_q <= channel_i;
      req_q  <= timeout_value_i;
    end
  end

  // Stored timeouts, written only by allocate
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && op_e'(op_q) == OP_ALLOC && alloc_hit) begin
      limit_q[alloc_idx] <= new_limit;
    end
  end

  // Channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q      <= '0;
      armed_q       <= '0;
      expire_q      <= '0;
      armed_total_q <= '0;
      for (int i = 0; i < Channels; i++) begin
        elapsed_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        expire_q <= '0;
      end
      if (cmd_i.exec) begin
        case (op_e'(op_q))
          OP_ALLOC: begin
            if (alloc_hit) begin
              in_use_q[alloc_idx]  <= 1'b1;
              armed_q[alloc_idx]   <= 1'b0;
              elapsed_q[alloc_idx] <= '0;
            end
          end
          OP_START: begin
            if (chan_ok && !armed_q[cidx]) begin
              armed_q[cidx] <= 1'b1;
              armed_total_q <= armed_total_q + 1'b1;
            end
          end
          OP_FEED: begin
            if (chan_ok && armed_q[cidx]) begin
              elapsed_q[cidx] <= '0;
            end
          end
          OP_STOP, OP_RELEASE: begin
            if (chan_ok) begin
              if (armed_q[cidx]) begin
                armed_q[cidx] <= 1'b0;
                armed_total_q <= armed_total_q - 1'b1;
              end
              elapsed_q[cidx] <= '0;
              if (op_e'(op_q) == OP_RELEASE) begin
                in_use_q[cidx] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.scan && armed_q[sidx]) begin
        if (scan_exp) begin
          armed_q[sidx]   <= 1'b0;
          in_use_q[sidx]  <= 1'b0;
          elapsed_q[sidx] <= '0;
          expire_q[sidx]  <= 1'b1;
          armed_total_q   <= armed_total_q - 1'b1;
        end else begin
          elapsed_q[sidx] <= sat_sum;
        end
      end
      if (cmd_i.emit) begin
        expire_q <= expire_rest;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q     <= KIND_EXPIRY;
      status_q   <= ST_OK;
      res_chan_q <= PortChW'(emit_idx);
      last_q     <= emit_last;
    end else if (cmd_i.exec) begin
      kind_q <= KIND_REPLY;
      last_q <= 1'b1;
      if (op_e'(op_q) == OP_ALLOC) begin
        status_q   <= alloc_hit ? ST_OK : ST_NO_FREE;
        res_chan_q <= alloc_hit ? PortChW'(alloc_idx) : '0;
      end else begin
        status_q   <= chan_ok ? ST_OK : ST_NOT_ALLOC;
        res_chan_q <= chan_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign status_o         = status_q;
  assign result_channel_o = res_chan_q;
  assign last_o           = last_q;

endmodule
